/* hdl/sra_pkg.sv */
`default_nettype none
package sra_pkg;

  localparam int MAX_RANGES = 128;
  localparam int OFF_W      = 32;
  localparam int IDX_W      = $clog2(MAX_RANGES);
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int TAIL_W     = OFF_W + 1;
  localparam int RND_W      = OFF_W + 2;

  localparam logic [31:0] HEAP_SIZE_RST = 32'd268435456;
  localparam logic [31:0] GRAN_RST      = 32'd1024;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_FIT    = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // register indexes
  localparam logic REG_HEAP_SIZE = 1'b0;
  localparam logic REG_GRAN      = 1'b1;

  typedef enum logic [1:0] {
    SH_NONE = 2'd0,
    SH_INS  = 2'd1,
    SH_DEL  = 2'd2
  } shift_t;

  // request values seen by every cell
  typedef struct packed {
    logic               kind;
    logic [OFF_W-1:0]   size;
    logic [OFF_W-1:0]   hs;
    logic [OFF_W-1:0]   al;
    logic [OFF_W-1:0]   coarse;
    logic [OFF_W-1:0]   fo;
    logic [CNT_W-1:0]   count;
  } bcast_t;

  // table update command
  typedef struct packed {
    shift_t             sh;
    logic [IDX_W-1:0]   pos;
    logic [OFF_W-1:0]   off;
    logic [OFF_W-1:0]   size;
    logic               kind;
    logic [TAIL_W-1:0]  tail;
  } cmd_t;

  // highest set bit, zero taken as one
  function automatic logic [31:0] pow2_floor(input logic [31:0] v);
    logic [31:0] r;
    r = 32'd1;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        r = '0;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [RND_W-1:0] round_up(input logic [TAIL_W-1:0] v,
                                                input logic [OFF_W-1:0] a);
    logic [RND_W-1:0] m;
    m = {2'b00, a} - RND_W'(1);
    return ({1'b0, v} + m) & ~m;
  endfunction

  // lowest set bit index
  function automatic logic [IDX_W-1:0] first_set(input logic [MAX_RANGES-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = MAX_RANGES - 1; i >= 0; i--) begin
      if (v[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/sorted_range_heap_allocator.sv */
// Sorted range allocator built as a chain of table cells.
// A request is taken only in S_IDLE; out_valid is registered from S_COMMIT.
// Each cell evaluates its own gap in two registered steps (bounds, then fit);
// the commit state tries the append slot, then the first fit, and shifts the chain.
// Reset (rst_n low, synchronous): table empty, free bytes = heap size,
// registers at defaults. Results cannot be stalled by the receiver.
`default_nettype none
module sorted_range_heap_allocator
  import sra_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_op,
  input  wire logic        in_resource_kind,
  input  wire logic [31:0] in_request_size,
  input  wire logic [31:0] in_request_alignment,
  input  wire logic [31:0] in_free_offset,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [31:0]      out_block_offset,
  output logic [31:0]      out_block_size,
  output logic [31:0]      out_space_left,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CALC   = 4'b0010,
    S_FIT    = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [31:0]       heap_r, gran_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [31:0]       free_r, free_nxt;
  logic              op_r;
  bcast_t            bc_r;

  logic [OFF_W-1:0]  c_off  [MAX_RANGES];
  logic [OFF_W-1:0]  c_size [MAX_RANGES];
  logic              c_kind [MAX_RANGES];
  logic [TAIL_W-1:0] c_tail [MAX_RANGES];
  logic [RND_W-1:0]  c_b    [MAX_RANGES];
  logic [MAX_RANGES-1:0] fit_v, match_v;

  logic [TAIL_W-1:0] last_tail_r;
  logic              last_kind_r;
  logic [RND_W-1:0]  end_r;
  logic              append_ok_r;
  logic [IDX_W-1:0]  last_idx;
  logic [RND_W-1:0]  end_nxt;

  cmd_t              cmd;
  logic [1:0]        st_nxt;
  logic [31:0]       boff_nxt, bsize_nxt;
  logic [IDX_W-1:0]  fit_idx, match_idx;
  logic [OFF_W:0]    free_sum;
  logic              cfg_wr, acc;
  logic [31:0]       al_in;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [31:0]       out_boff_r, out_bsize_r;

  assign acc    = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_GRAN) ? gran_r : heap_r;
  assign al_in  = pow2_floor(in_request_alignment);

  // cell chain
  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
    logic [OFF_W-1:0]  l_off, l_size, r_off, r_size;
    logic              l_kind, r_kind;
    logic [TAIL_W-1:0] l_tail, r_tail;
    if (i == 0) begin : g_lz
      assign l_off = '0; assign l_size = '0; assign l_kind = 1'b0; assign l_tail = '0;
    end else begin : g_ln
      assign l_off  = c_off[i-1];
      assign l_size = c_size[i-1];
      assign l_kind = c_kind[i-1];
      assign l_tail = c_tail[i-1];
    end
    if (i == MAX_RANGES - 1) begin : g_rz
      assign r_off = '0; assign r_size = '0; assign r_kind = 1'b0; assign r_tail = '0;
    end else begin : g_rn
      assign r_off  = c_off[i+1];
      assign r_size = c_size[i+1];
      assign r_kind = c_kind[i+1];
      assign r_tail = c_tail[i+1];
    end
    sra_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(i)),
      .bc         (bc_r),
      .cmd        (cmd),
      .left_off   (l_off),
      .left_size  (l_size),
      .left_kind  (l_kind),
      .left_tail  (l_tail),
      .right_off  (r_off),
      .right_size (r_size),
      .right_kind (r_kind),
      .right_tail (r_tail),
      .off        (c_off[i]),
      .size       (c_size[i]),
      .kind       (c_kind[i]),
      .tail       (c_tail[i]),
      .gap_b      (c_b[i]),
      .fit        (fit_v[i]),
      .match      (match_v[i])
    );
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (start) state_nxt = S_CALC;
      S_CALC:   state_nxt = S_FIT;
      S_FIT:    state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // append candidate after the last entry
  assign last_idx = IDX_W'(count_r - CNT_W'(1));
  assign end_nxt  = round_up(last_tail_r, (last_kind_r == bc_r.kind) ? bc_r.al : bc_r.coarse);

  always_ff @(posedge clk) begin
    last_tail_r <= c_tail[last_idx];
    last_kind_r <= c_kind[last_idx];
    end_r       <= end_nxt;
    append_ok_r <= (end_nxt <= {2'b00, bc_r.hs}) &&
                   (({2'b00, bc_r.hs} - end_nxt) >= {2'b00, bc_r.size});
  end

  // commit decision
  assign fit_idx   = first_set(fit_v);
  assign match_idx = first_set(match_v);
  assign free_sum  = {1'b0, free_r} + {1'b0, c_size[match_idx]};

  always_comb begin
    cmd       = '0;
    cmd.sh    = SH_NONE;
    cmd.kind  = bc_r.kind;
    cmd.size  = bc_r.size;
    st_nxt    = ST_NO_FIT;
    boff_nxt  = '0;
    bsize_nxt = '0;
    count_nxt = count_r;
    free_nxt  = free_r;
    if (op_r == OP_FREE) begin
      boff_nxt = bc_r.fo;
      if (|match_v) begin
        st_nxt    = ST_OK;
        bsize_nxt = c_size[match_idx];
        cmd.sh    = SH_DEL;
        cmd.pos   = match_idx;
        count_nxt = count_r - CNT_W'(1);
        free_nxt  = free_sum[OFF_W] ? '1 : free_sum[OFF_W-1:0];
      end else begin
        st_nxt = ST_NOT_FOUND;
      end
    end else if (count_r == CNT_W'(MAX_RANGES)) begin
      st_nxt = ST_FULL;
    end else begin
      if (count_r == '0) begin
        if (bc_r.size <= bc_r.hs) begin
          st_nxt  = ST_OK;
          cmd.sh  = SH_INS;
          cmd.pos = '0;
          cmd.off = '0;
        end
      end else if (append_ok_r) begin
        st_nxt  = ST_OK;
        cmd.sh  = SH_INS;
        cmd.pos = IDX_W'(count_r);
        cmd.off = end_r[OFF_W-1:0];
      end else if (|fit_v) begin
        st_nxt  = ST_OK;
        cmd.sh  = SH_INS;
        cmd.pos = fit_idx + IDX_W'(1);
        cmd.off = c_b[fit_idx][OFF_W-1:0];
      end
      if (st_nxt == ST_OK) begin
        boff_nxt  = cmd.off;
        bsize_nxt = bc_r.size;
        count_nxt = count_r + CNT_W'(1);
        free_nxt  = (free_r >= bc_r.size) ? free_r - bc_r.size : '0;
      end
    end
    cmd.tail = {1'b0, cmd.off} + {1'b0, cmd.size};
    if (state_r != S_COMMIT) begin
      cmd.sh = SH_NONE;
    end
  end

  // control and status registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      heap_r      <= HEAP_SIZE_RST;
      gran_r      <= GRAN_RST;
      count_r     <= '0;
      free_r      <= HEAP_SIZE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_COMMIT);
      if (state_r == S_COMMIT) begin
        count_r <= count_nxt;
        free_r  <= free_nxt;
      end else if (cfg_wr && paddr[2] == REG_HEAP_SIZE) begin
        heap_r <= pwdata;
        if (count_r == '0) free_r <= pwdata;
      end else if (cfg_wr && paddr[2] == REG_GRAN) begin
        gran_r <= pwdata;
      end
    end
  end

  // request word and result word
  always_ff @(posedge clk) begin
    if (acc) begin
      op_r        <= in_op;
      bc_r.kind   <= in_resource_kind;
      bc_r.size   <= in_request_size;
      bc_r.hs     <= heap_r;
      bc_r.al     <= al_in;
      bc_r.coarse <= (al_in > pow2_floor(gran_r)) ? al_in : pow2_floor(gran_r);
      bc_r.fo     <= in_free_offset;
    end
    bc_r.count <= count_r;
    if (state_r == S_COMMIT) begin
      out_status_r <= st_nxt;
      out_boff_r   <= boff_nxt;
      out_bsize_r  <= bsize_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_block_offset = out_boff_r;
  assign out_block_size   = out_bsize_r;
  assign out_space_left   = free_r;

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RANGES)) else $error("entry count out of range");

  a_result_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == S_COMMIT) else $error("stray result");

  a_free_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT && op_r == OP_FREE && st_nxt == ST_OK)
    |=> count_r == $past(count_r) - CNT_W'(1)) else $error("free did not remove entry");

  a_alloc_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT && op_r == OP_ALLOC && st_nxt == ST_OK)
    |=> count_r == $past(count_r) + CNT_W'(1)) else $error("alloc did not add entry");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> busy) else $error("accepted word without going busy");

endmodule
`default_nettype wire

/* hdl/sra_cell.sv */
`default_nettype none
module sra_cell
  import sra_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [IDX_W-1:0]  cell_idx,
  input  wire bcast_t            bc,
  input  wire cmd_t              cmd,
  input  wire logic [OFF_W-1:0]  left_off,
  input  wire logic [OFF_W-1:0]  left_size,
  input  wire logic              left_kind,
  input  wire logic [TAIL_W-1:0] left_tail,
  input  wire logic [OFF_W-1:0]  right_off,
  input  wire logic [OFF_W-1:0]  right_size,
  input  wire logic              right_kind,
  input  wire logic [TAIL_W-1:0] right_tail,
  output logic [OFF_W-1:0]       off,
  output logic [OFF_W-1:0]       size,
  output logic                   kind,
  output logic [TAIL_W-1:0]      tail,
  output logic [RND_W-1:0]       gap_b,
  output logic                   fit,
  output logic                   match
);

  logic [OFF_W-1:0]  off_r, size_r;
  logic              kind_r;
  logic [TAIL_W-1:0] tail_r;
  logic [RND_W-1:0]  b_r, e_r;
  logic              gap_ok_r, fit_r, match_r;

  logic              same_here, same_next;
  logic [OFF_W-1:0]  a_here, a_next;
  logic [RND_W-1:0]  b_nxt, e_nxt;
  logic              gap_ok_nxt, match_nxt, fit_nxt;

  // entry storage, shifted on insert and erase
  always_ff @(posedge clk) begin
    case (cmd.sh)
      SH_INS: begin
        if (cell_idx == cmd.pos) begin
          off_r  <= cmd.off;
          size_r <= cmd.size;
          kind_r <= cmd.kind;
          tail_r <= cmd.tail;
        end else if (cell_idx > cmd.pos) begin
          off_r  <= left_off;
          size_r <= left_size;
          kind_r <= left_kind;
          tail_r <= left_tail;
        end
      end
      SH_DEL: begin
        if (cell_idx >= cmd.pos) begin
          off_r  <= right_off;
          size_r <= right_size;
          kind_r <= right_kind;
          tail_r <= right_tail;
        end
      end
      default: ;
    endcase
  end

  // gap bounds between this entry and the next
  always_comb begin
    same_here  = (kind_r == bc.kind);
    same_next  = (right_kind == bc.kind);
    a_here     = same_here ? bc.al : bc.coarse;
    a_next     = same_next ? bc.al : bc.coarse;
    b_nxt      = round_up(tail_r, a_here);
    if (same_here && same_next) begin
      e_nxt = {2'b00, right_off};
    end else begin
      e_nxt = {2'b00, right_off & ~(a_next - OFF_W'(1))};
    end
    gap_ok_nxt = ({1'b0, cell_idx} + CNT_W'(1)) < bc.count;
    match_nxt  = ({1'b0, cell_idx} < bc.count) && (off_r == bc.fo);
  end

  // fit test on registered bounds
  always_comb begin
    fit_nxt = gap_ok_r && (e_r >= b_r) && ((e_r - b_r) >= {2'b00, bc.size}) &&
              (b_r <= {2'b00, bc.hs}) && (({2'b00, bc.hs} - b_r) >= {2'b00, bc.size});
  end

  always_ff @(posedge clk) begin
    b_r      <= b_nxt;
    e_r      <= e_nxt;
    gap_ok_r <= gap_ok_nxt;
    match_r  <= match_nxt;
    fit_r    <= fit_nxt;
  end

  assign off   = off_r;
  assign size  = size_r;
  assign kind  = kind_r;
  assign tail  = tail_r;
  assign gap_b = b_r;
  assign fit   = fit_r;
  assign match = match_r;

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 100ps
module tb_top;
  import sra_pkg::*;

  typedef struct {
    logic        op;
    logic        kind;
    logic [31:0] size;
    logic [31:0] align;
    logic [31:0] foff;
  } req_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] boff;
    logic [31:0] bsize;
    logic [31:0] left;
  } res_t;

  logic clk, rst_n, start, busy;
  logic in_op, in_resource_kind;
  logic [31:0] in_request_size, in_request_alignment, in_free_offset;
  logic out_valid;
  logic [1:0] out_status;
  logic [31:0] out_block_offset, out_block_size, out_space_left;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  sorted_range_heap_allocator DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_resource_kind(in_resource_kind),
    .in_request_size(in_request_size), .in_request_alignment(in_request_alignment),
    .in_free_offset(in_free_offset),
    .out_valid(out_valid), .out_status(out_status), .out_block_offset(out_block_offset),
    .out_block_size(out_block_size), .out_space_left(out_space_left),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow heap state
  longint unsigned heap_bytes, gran_reg, free_cnt;
  longint unsigned tbl_off[MAX_RANGES];
  longint unsigned tbl_size[MAX_RANGES];
  bit tbl_kind[MAX_RANGES];
  int tbl_n;

  req_t pending_reqs[$];
  res_t alloc_results[$];
  bit   accepted;
  bit   no_idle;
  bit   errors;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned pow2_down(longint unsigned v);
    longint unsigned p;
    p = 1;
    if (v == 0) return 1;
    while ((p << 1) <= v) p = p << 1;
    return p;
  endfunction

  function automatic longint unsigned ceil_to(longint unsigned v, longint unsigned a);
    return (v + a - 1) & ~(a - 1);
  endfunction

  // insert one range at pos, shifting the tail up
  function automatic void insert_range(int pos, longint unsigned off, longint unsigned sz,
                                       bit k);
    for (int j = tbl_n; j > pos; j--) begin
      tbl_off[j] = tbl_off[j-1];
      tbl_size[j] = tbl_size[j-1];
      tbl_kind[j] = tbl_kind[j-1];
    end
    tbl_off[pos] = off;
    tbl_size[pos] = sz;
    tbl_kind[pos] = k;
    tbl_n++;
    free_cnt = (free_cnt >= sz) ? free_cnt - sz : 0;
  endfunction

  // work out the result of one accepted word and update the shadow table
  function automatic res_t heap_predict(req_t r);
    res_t o;
    longint unsigned sz, al, fo, gr, coarse, a, e, b, tail, nxt;
    int i, last;
    bit here, next;
    sz = r.size;
    al = pow2_down(r.align);
    fo = r.foff;
    gr = pow2_down(gran_reg);
    coarse = (al > gr) ? al : gr;
    o.status = ST_NO_FIT;
    o.boff = '0;
    o.bsize = '0;
    if (r.op == OP_FREE) begin
      i = 0;
      while (i < tbl_n && tbl_off[i] < fo) i++;
      if (i < tbl_n && tbl_off[i] == fo) begin
        o.bsize = tbl_size[i][31:0];
        o.boff = fo[31:0];
        free_cnt = free_cnt + tbl_size[i];
        if (free_cnt > 64'hFFFF_FFFF) free_cnt = 64'hFFFF_FFFF;
        for (int j = i; j < tbl_n - 1; j++) begin
          tbl_off[j] = tbl_off[j+1];
          tbl_size[j] = tbl_size[j+1];
          tbl_kind[j] = tbl_kind[j+1];
        end
        tbl_n--;
        o.status = ST_OK;
      end else begin
        o.status = ST_NOT_FOUND;
        o.boff = fo[31:0];
      end
    end else if (tbl_n >= MAX_RANGES) begin
      o.status = ST_FULL;
    end else if (tbl_n == 0) begin
      if (sz <= heap_bytes) begin
        insert_range(0, 0, sz, r.kind);
        o.status = ST_OK;
        o.bsize = sz[31:0];
      end
    end else begin
      last = tbl_n - 1;
      a = (tbl_kind[last] == r.kind) ? al : coarse;
      e = ceil_to(tbl_off[last] + tbl_size[last], a);
      if (e <= heap_bytes && heap_bytes - e >= sz) begin
        insert_range(tbl_n, e, sz, r.kind);
        o.status = ST_OK;
        o.boff = e[31:0];
        o.bsize = sz[31:0];
      end else begin
        // first inner gap that fits
        for (i = 0; i + 1 < tbl_n; i++) begin
          tail = tbl_off[i] + tbl_size[i];
          nxt = tbl_off[i+1];
          here = tbl_kind[i] == r.kind;
          next = tbl_kind[i+1] == r.kind;
          if (here && next) begin
            b = ceil_to(tail, al);
            e = nxt;
          end else begin
            b = ceil_to(tail, here ? al : coarse);
            e = nxt & ~((next ? al : coarse) - 1);
          end
          if (e >= b && e - b >= sz && b <= heap_bytes && heap_bytes - b >= sz) begin
            insert_range(i + 1, b, sz, r.kind);
            o.status = ST_OK;
            o.boff = b[31:0];
            o.bsize = sz[31:0];
            break;
          end
        end
      end
    end
    o.left = free_cnt[31:0];
    return o;
  endfunction

  // driver: new word at the falling edge once the previous one was taken
  always @(negedge clk) begin
    if (rst_n && (!start || accepted)) begin
      if (pending_reqs.size() > 0 && (no_idle || $urandom_range(0, 99) >= 25)) begin
        req_t r;
        r = pending_reqs.pop_front();
        in_op <= r.op;
        in_resource_kind <= r.kind;
        in_request_size <= r.size;
        in_request_alignment <= r.align;
        in_free_offset <= r.foff;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check results, then predict for the word taken at this edge
  always @(posedge clk) begin
    res_t x;
    req_t r;
    accepted <= rst_n && start && !busy;
    if (rst_n && out_valid) begin
      if (alloc_results.size() == 0) begin
        $display("%0t: unexpected result status %0d offset %h", $time, out_status,
                 out_block_offset);
        errors = 1'b1;
      end else begin
        x = alloc_results.pop_front();
        if (out_status !== x.status) begin
          $display("%0t: status expected %0d actual %0d", $time, x.status, out_status);
          errors = 1'b1;
        end
        if (out_block_offset !== x.boff) begin
          $display("%0t: block_offset expected %h actual %h", $time, x.boff,
                   out_block_offset);
          errors = 1'b1;
        end
        if (out_block_size !== x.bsize) begin
          $display("%0t: block_size expected %h actual %h", $time, x.bsize, out_block_size);
          errors = 1'b1;
        end
        if (out_space_left !== x.left) begin
          $display("%0t: space_left expected %h actual %h", $time, x.left, out_space_left);
          errors = 1'b1;
        end
      end
    end
    if (rst_n && start && !busy) begin
      r.op = in_op;
      r.kind = in_resource_kind;
      r.size = in_request_size;
      r.align = in_request_alignment;
      r.foff = in_free_offset;
      alloc_results.push_back(heap_predict(r));
    end
  end

  // register write, only while idle
  task automatic reg_write(logic idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_HEAP_SIZE) begin
      heap_bytes = val;
      if (tbl_n == 0) free_cnt = val;
    end else begin
      gran_reg = val;
    end
  endtask

  task automatic drain;
    do @(posedge clk);
    while (pending_reqs.size() > 0 || start || alloc_results.size() > 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic push_req(logic op, logic k, logic [31:0] sz, logic [31:0] al,
                          logic [31:0] fo);
    req_t r;
    r.op = op;
    r.kind = k;
    r.size = sz;
    r.align = al;
    r.foff = fo;
    pending_reqs.push_back(r);
  endtask

  // random word; frees mostly hit a live range
  task automatic push_random(int alloc_pct, int max_sz);
    logic [31:0] sz, al, fo;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) sz = $urandom();
    else if (pick < 8) sz = '0;
    else sz = $urandom_range(1, max_sz);
    pick = $urandom_range(0, 99);
    if (pick < 8) al = $urandom();
    else if (pick < 11) al = 32'h8000_0000;
    else al = 32'd1 << $urandom_range(0, 10);
    if (tbl_n > 0 && $urandom_range(0, 99) < 85) begin
      pick = $urandom_range(0, tbl_n - 1);
      fo = tbl_off[pick][31:0];
    end else begin
      fo = $urandom();
    end
    push_req(($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE,
             $urandom_range(0, 1), sz, al, fo);
  endtask

  task automatic run_random(int n, int alloc_pct, int max_sz);
    for (int k = 0; k < n; k++) begin
      while (pending_reqs.size() > 0) @(posedge clk);
      push_random(alloc_pct, max_sz);
    end
    drain();
  endtask

  initial begin
    #20_000_000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    accepted = 1'b0;
    no_idle = 1'b0;
    errors = 1'b0;
    in_op = OP_ALLOC;
    in_resource_kind = 1'b0;
    in_request_size = '0;
    in_request_alignment = 32'd1;
    in_free_offset = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    heap_bytes = HEAP_SIZE_RST;
    gran_reg = GRAN_RST;
    free_cnt = HEAP_SIZE_RST;
    tbl_n = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, oversize, odd alignments, kind changes
    push_req(OP_FREE, 1'b0, 32'd0, 32'd1, 32'd0);
    push_req(OP_ALLOC, 1'b0, 32'hFFFF_FFFF, 32'd1, 32'd0);
    push_req(OP_ALLOC, 1'b0, 32'd0, 32'd0, 32'd0);
    push_req(OP_ALLOC, 1'b0, 32'd100, 32'd3, 32'd0);
    push_req(OP_ALLOC, 1'b1, 32'd100, 32'd16, 32'd0);
    push_req(OP_ALLOC, 1'b1, 32'd5, 32'h8000_0000, 32'd0);
    push_req(OP_ALLOC, 1'b0, 32'd200, 32'd8, 32'd0);
    push_req(OP_FREE, 1'b0, 32'd0, 32'd1, 32'd1024);
    push_req(OP_FREE, 1'b0, 32'd0, 32'd1, 32'd1025);
    push_req(OP_ALLOC, 1'b0, 32'd64, 32'd4, 32'd0);
    push_req(OP_ALLOC, 1'b1, 32'd64, 32'd4, 32'd0);
    push_req(OP_FREE, 1'b0, 32'd0, 32'd1, 32'hFFFF_FFFF);
    push_req(OP_ALLOC, 1'b0, 32'h1000_0000, 32'd1, 32'd0);
    drain();
    while (tbl_n > 0) begin
      push_req(OP_FREE, 1'b0, 32'd0, 32'd1, tbl_off[0][31:0]);
      drain();
    end
    push_req(OP_ALLOC, 1'b1, HEAP_SIZE_RST, 32'd1, 32'd0);
    push_req(OP_ALLOC, 1'b0, 32'd1, 32'd1, 32'd0);
    push_req(OP_FREE, 1'b1, 32'd0, 32'd1, 32'd0);
    drain();

    // defaults, then fill the table to overflow with no idling
    run_random(250, 60, 4096);
    no_idle = 1'b1;
    run_random(250, 95, 64);
    no_idle = 1'b0;

    // heap size rewritten while ranges are live, granularity extremes
    reg_write(REG_GRAN, 32'd1);
    reg_write(REG_HEAP_SIZE, 32'd20000);
    run_random(250, 55, 2048);
    reg_write(REG_GRAN, 32'h8000_0000);
    reg_write(REG_HEAP_SIZE, 32'hFFFF_FFFF);
    run_random(200, 60, 65536);
    reg_write(REG_GRAN, 32'd0);
    reg_write(REG_HEAP_SIZE, 32'd0);
    run_random(150, 50, 512);
    reg_write(REG_GRAN, 32'd300);
    reg_write(REG_HEAP_SIZE, 32'd4096);
    run_random(200, 60, 256);
    reg_write(REG_GRAN, GRAN_RST);
    reg_write(REG_HEAP_SIZE, 32'h7FFF_FFFF);
    run_random(200, 60, 4096);

    if (!errors && alloc_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
